@@ sv/ar1sd_pkg.sv @@
// ----------------------------------------------------------------------------
// ar1sd_pkg
// Shared types, constants and fixed-point helpers for the AR(1) deconvolver.
// ----------------------------------------------------------------------------
package ar1sd_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam logic [15:0] DECAY_RST   = 16'd62259;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  localparam logic [1:0] CFG_DECAY   = 2'd0;
  localparam logic [1:0] CFG_PENALTY = 2'd1;
  localparam logic [1:0] CFG_MINSPK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_RD_C,
    S_RD_P,
    S_DIV_C,
    S_DIV_P,
    S_CMP,
    S_MERGE,
    S_RO_RD,
    S_RO_DIV,
    S_RO_OUT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // a * b >> 16 with the sign of a, magnitude truncated toward zero, a signed 49 bits, b up to 2^16
  function automatic logic signed [48:0] mulq(input logic signed [48:0] a,
                                               input logic [16:0] b);
    logic [48:0] m;
    logic [65:0] p;
    logic [48:0] r;
    m = a[48] ? 49'(-a) : 49'(a);
    p = m * b;
    r = p[64:16];
    return a[48] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > 50'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (x < -50'sh800000000000) return 48'sh800000000000;
    return x[47:0];
  endfunction

endpackage

@@ sv/ar1sd_div.sv @@
// ----------------------------------------------------------------------------
// ar1sd_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, unsigned.
// ----------------------------------------------------------------------------
module ar1sd_div
  import ar1sd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] q_r;
  logic [48:0] rem_r;
  logic [47:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [48:0] trial;

  assign trial = {rem_r[47:0], q_r[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        q_r    <= {req.num, 16'h0};
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        if (!trial[48]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[47:0], q_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = (den_r == '0) ? 64'd0 : q_r;

endmodule

@@ sv/ar1_spike_deconvolution.sv @@
// ----------------------------------------------------------------------------
// ar1_spike_deconvolution
// Pool-adjacent-violators AR(1) spike deconvolution over a pool-stack memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake       payload
// in_      input      valid / stall   kind, sample, is_final
// out_     output     valid / stall   calcium, spike, last_out, status
// cfg_     input      valid / ready   index, data
//
// in_stall is high outside idle: a dropped push stalls through the push state, a
// push onto an empty stack also through the top-pool read, any other push through
// a compare plus one per merge (each waits on two divides). A readout at a pool
// start waits on one divide; longer while a held result waits on out_stall.
// Synchronous active-low reset; the pool memory is not cleared. The result
// register holds while out_stall; a staging register frees the compute side.
module ar1_spike_deconvolution
  import ar1sd_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_sample,
  input  logic               in_is_final,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_calcium,
  output logic signed [31:0] out_spike,
  output logic               out_last_out,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] LIM = CW'(MAX_LEN);

  typedef struct packed {
    logic signed [47:0] val;
    logic [47:0]        wgt;
    logic [AW-1:0]      start;
    logic [CW-1:0]      len;
    logic [15:0]        pw;
  } pool_t;

  pool_t mem [MAX_LEN];
  pool_t rd_q;
  logic [AW-1:0] rd_a;
  logic          we;
  logic [AW-1:0] wa;
  pool_t         wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  logic [15:0] decay_r;
  logic [30:0] pen_r, smin_r;
  state_t st_r, st_nxt;
  logic [CW-1:0] pcnt_r, scnt_r, ridx_r, rpool_r;
  logic ovf_r;
  logic signed [31:0] run_r, prev_r;
  pool_t cur_r, prv_r;
  logic signed [48:0] mc_r, mp_r;
  logic fin_r;
  logic signed [31:0] samp_r;
  logic [30:0] ocal_r;
  logic signed [31:0] ospk_r;
  logic olast_r, oval_r;
  logic [1:0] ost_r;
  logic [30:0] res_cal_r;
  logic signed [31:0] res_spk_r;
  logic res_last_r;
  logic [1:0] res_st_r;
  logic startp_r;
  logic ro_started_r;
  logic [15:0] shw_r;
  logic hit;

  div_req_t dreq;
  div_rsp_t drsp;
  ar1sd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = (st_r == S_IDLE);
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = oval_r;
  assign out_calcium = ocal_r;
  assign out_spike = ospk_r;
  assign out_last_out = olast_r;
  assign out_status = ost_r;

  assign hit = (rpool_r < pcnt_r) && (AW'(ridx_r) == rd_q.start) && (ridx_r < LIM);

  // signed mean from divider quotient
  function automatic logic signed [48:0] mean_of(input logic neg, input logic [63:0] q);
    logic [48:0] m;
    m = q[48:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  logic signed [48:0] lhs;
  logic signed [49:0] vsum;
  logic [49:0] wsum;
  logic signed [48:0] shw;
  logic signed [48:0] mclamp;
  logic signed [48:0] rdec, pdec;
  logic signed [31:0] cal_nxt;

  always_comb begin
    lhs  = mulq(mp_r, {1'b0, prv_r.pw});
    shw  = mulq(49'(prv_r.pw), {1'b0, prv_r.pw});
    vsum = 50'(prv_r.val) + 50'(mulq(49'(cur_r.val), {1'b0, prv_r.pw}));
    wsum = 50'(prv_r.wgt) + 50'($unsigned(mulq($signed({1'b0, cur_r.wgt}), {1'b0, shw_r})));
    mclamp = mc_r[48] ? 49'sd0 : (mc_r > 49'sh7FFFFFFF ? 49'sh7FFFFFFF : mc_r);
    rdec = mulq(49'(run_r), {1'b0, decay_r});
    pdec = mulq(49'(prev_r), {1'b0, decay_r});
    cal_nxt = startp_r ? mclamp[31:0] : ((ridx_r == '0) ? run_r : rdec[31:0]);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        if (in_kind) st_nxt = (scnt_r == '0) ? S_OUT : S_RO_RD;
        else st_nxt = S_PUSH;
      end
      S_PUSH:  st_nxt = (scnt_r >= LIM || pcnt_r >= LIM) ? S_IDLE : S_RD_C;
      S_RD_C:  st_nxt = (pcnt_r > 1) ? S_RD_P : S_IDLE;
      S_RD_P:  st_nxt = S_DIV_C;
      S_DIV_C: if (drsp.done) st_nxt = S_DIV_P;
      S_DIV_P: if (drsp.done) st_nxt = S_CMP;
      S_CMP:   st_nxt = (lhs + $signed(49'(smin_r)) > mc_r) ? S_MERGE : S_IDLE;
      S_MERGE: st_nxt = S_RD_C;
      S_RO_RD: st_nxt = S_RO_DIV;
      S_RO_DIV: begin
        if (!ro_started_r) st_nxt = hit ? S_RO_DIV : S_RO_OUT;
        else if (drsp.done) st_nxt = S_RO_OUT;
      end
      S_RO_OUT: st_nxt = S_OUT;
      S_OUT:   if (!oval_r || !out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_a = AW'(pcnt_r - CW'(2));
    we = 1'b0;
    wa = AW'(pcnt_r);
    wd = cur_r;
    dreq = '0;
    case (st_r)
      S_RD_C: rd_a = AW'(pcnt_r - CW'(1));
      S_RO_RD, S_RO_DIV, S_RO_OUT: rd_a = AW'(rpool_r);
      S_MERGE: begin
        we = 1'b1;
        wa = AW'(pcnt_r - CW'(2));
        wd = prv_r;
        wd.val = sat48(vsum);
        wd.wgt = wsum[49:48] != 2'b00 ? 48'hFFFFFFFFFFFF : wsum[47:0];
        wd.len = prv_r.len + cur_r.len;
        wd.pw  = 16'(mulq(49'(prv_r.pw), {1'b0, cur_r.pw}));
      end
      default: ;
    endcase
    if (st_r == S_PUSH && !(scnt_r >= LIM || pcnt_r >= LIM)) begin
      we = 1'b1;
      wa = AW'(pcnt_r);
      wd.val = sat48(50'(samp_r) - 50'(fin_r ? 49'(pen_r)
                    : mulq(49'(pen_r), ONE_Q16 - 17'(decay_r))));
      wd.wgt = 48'h10000;
      wd.start = AW'(scnt_r);
      wd.len = CW'(1);
      wd.pw = decay_r;
    end
    if (st_r == S_RD_P) begin
      dreq.start = 1'b1;
      dreq.num = rd_q.val[47] ? 48'(-rd_q.val) : rd_q.val;
      dreq.den = rd_q.wgt;
    end
    if (st_r == S_DIV_C && drsp.done) begin
      dreq.start = 1'b1;
      dreq.num = rd_q.val[47] ? 48'(-rd_q.val) : rd_q.val;
      dreq.den = rd_q.wgt;
    end
    if (st_r == S_RO_DIV && !ro_started_r && hit) begin
      dreq.start = 1'b1;
      dreq.num = rd_q.val[47] ? 48'(-rd_q.val) : rd_q.val;
      dreq.den = rd_q.wgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      decay_r <= DECAY_RST;
      pen_r <= '0;
      smin_r <= '0;
      pcnt_r <= '0;
      scnt_r <= '0;
      ovf_r <= 1'b0;
      ridx_r <= '0;
      rpool_r <= '0;
      run_r <= '0;
      prev_r <= '0;
      oval_r <= 1'b0;
      ro_started_r <= 1'b0;
      startp_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && (!oval_r || !out_stall)) begin
        oval_r  <= 1'b1;
        ocal_r  <= res_cal_r;
        ospk_r  <= res_spk_r;
        olast_r <= res_last_r;
        ost_r   <= res_st_r;
      end else if (oval_r && !out_stall) oval_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DECAY:   decay_r <= cfg_data[15:0];
          CFG_PENALTY: pen_r <= cfg_data[30:0];
          CFG_MINSPK:  smin_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: if (in_valid) begin
          samp_r <= in_sample;
          fin_r <= in_is_final;
          if (in_kind && scnt_r == '0) begin
            res_cal_r <= '0; res_spk_r <= '0; res_last_r <= 1'b0; res_st_r <= ST_EMPTY;
          end
        end
        S_PUSH: begin
          ridx_r <= '0; rpool_r <= '0; run_r <= '0; prev_r <= '0;
          if (scnt_r >= LIM || pcnt_r >= LIM) ovf_r <= 1'b1;
          else begin
            pcnt_r <= pcnt_r + CW'(1);
            scnt_r <= scnt_r + CW'(1);
          end
        end
        S_RD_P: cur_r <= rd_q;
        S_DIV_C: if (drsp.done) begin
          mc_r <= mean_of(cur_r.val[47], drsp.quo);
          prv_r <= rd_q;
        end
        S_DIV_P: if (drsp.done) mp_r <= mean_of(prv_r.val[47], drsp.quo);
        S_CMP: shw_r <= shw[15:0];
        S_MERGE: pcnt_r <= pcnt_r - CW'(1);
        S_RO_RD: ro_started_r <= 1'b0;
        S_RO_DIV: begin
          cur_r <= rd_q;
          if (!ro_started_r) begin
            ro_started_r <= 1'b1;
            startp_r <= hit;
          end else if (drsp.done) mc_r <= mean_of(cur_r.val[47], drsp.quo);
        end
        S_RO_OUT: begin
          res_cal_r <= cal_nxt[30:0];
          res_spk_r <= (ridx_r == '0) ? 32'sd0 : 32'($signed(49'(cal_nxt)) - pdec);
          res_last_r <= (ridx_r + CW'(1) == scnt_r);
          res_st_r <= ovf_r ? ST_OVERFLOW : ST_OK;
          if (ridx_r + CW'(1) >= scnt_r) begin
            ridx_r <= '0; rpool_r <= '0; run_r <= '0; prev_r <= '0;
          end else begin
            ridx_r <= ridx_r + CW'(1);
            run_r <= cal_nxt;
            prev_r <= cal_nxt;
            if (rpool_r < pcnt_r &&
                (ridx_r + CW'(1)) >= CW'(cur_r.start) + cur_r.len)
              rpool_r <= rpool_r + CW'(1);
          end
          startp_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
